@@ rtl/utf8_sanitizer_assert.svh @@
// Assertion macros for the UTF-8 sanitizer checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef UTF8_SANITIZER_ASSERT_SVH
`define UTF8_SANITIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define UTF8S_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utf8_sanitizer assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define UTF8S_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utf8_sanitizer assertion failed");

`endif

@@ rtl/utf8s_pkg.sv @@
// Shared types and constants of the UTF-8 sanitizer.
// No dependencies; used by the front end, command queue, back end and top level.
package utf8s_pkg;

    // Replacement character U+FFFD as UTF-8
    localparam logic [7:0] REPL_B0 = 8'hEF;
    localparam logic [7:0] REPL_B1 = 8'hBF;
    localparam logic [7:0] REPL_B2 = 8'hBD;

    // Lead byte ranges
    localparam logic [7:0] LEAD2_LO = 8'hC2;
    localparam logic [7:0] LEAD2_HI = 8'hDF;
    localparam logic [7:0] LEAD3_LO = 8'hE0;
    localparam logic [7:0] LEAD3_HI = 8'hEF;
    localparam logic [7:0] LEAD4_LO = 8'hF0;
    localparam logic [7:0] LEAD4_HI = 8'hF4;

    // Code point limits
    localparam logic [20:0] MIN_CODE_2 = 21'h00080;
    localparam logic [20:0] MIN_CODE_3 = 21'h00800;
    localparam logic [20:0] MIN_CODE_4 = 21'h10000;
    localparam logic [20:0] MAX_CODE   = 21'h10FFFF;
    localparam logic [20:0] SURR_LO    = 21'h0D800;
    localparam logic [20:0] SURR_HI    = 21'h0DFFF;

    // Sequence lengths
    localparam logic [2:0] SEQ_LEN_NONE = 3'd0;
    localparam logic [2:0] SEQ_LEN_2    = 3'd2;
    localparam logic [2:0] SEQ_LEN_3    = 3'd3;
    localparam logic [2:0] SEQ_LEN_4    = 3'd4;

    // Command queue geometry
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Emission command: repl_cnt replacement characters, then raw_cnt raw bytes
    typedef struct packed {
        logic [2:0]      repl_cnt;
        logic [2:0]      raw_cnt;
        logic [3:0][7:0] raw;
        logic            fin;
    } cmd_t;

endpackage

@@ rtl/utf8s_front.sv @@
// Front end of the UTF-8 sanitizer: decodes input bytes, holds partial
// sequences and builds emission commands. Depends on utf8s_pkg.
module utf8s_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       in_byte,
    input  logic             final_byte,
    input  logic             accept,
    output utf8s_pkg::cmd_t  cmd,
    output logic             cmd_valid
);

    logic [1:0]       pc_reg;
    logic [1:0]       pc_next;
    logic [2:0]       el_reg;
    logic [2:0]       el_next;
    logic [20:0]      acc_reg;
    logic [20:0]      acc_next;
    logic [2:0][7:0]  pend_reg;
    logic             pend_we;
    logic [1:0]       pend_idx;

    logic             is_cont;
    logic [2:0]       pc_inc;
    logic [20:0]      acc_shift;
    logic             complete;
    logic [20:0]      min_code;
    logic             code_ok;
    logic [2:0]       lead_len;
    logic [20:0]      lead_bits;

    // Classify the byte and check the code point
    always_comb
    begin
        is_cont   = (in_byte[7:6] == 2'b10);
        pc_inc    = {1'b0, pc_reg} + 3'd1;
        acc_shift = {acc_reg[14:0], in_byte[5:0]};
        complete  = (pc_inc >= el_reg);
        case (el_reg)
            utf8s_pkg::SEQ_LEN_2: min_code = utf8s_pkg::MIN_CODE_2;
            utf8s_pkg::SEQ_LEN_3: min_code = utf8s_pkg::MIN_CODE_3;
            default:              min_code = utf8s_pkg::MIN_CODE_4;
        endcase
        code_ok = (acc_shift >= min_code) && (acc_shift <= utf8s_pkg::MAX_CODE) &&
                  !((acc_shift >= utf8s_pkg::SURR_LO) && (acc_shift <= utf8s_pkg::SURR_HI));

        lead_len  = utf8s_pkg::SEQ_LEN_NONE;
        lead_bits = '0;
        if (in_byte >= utf8s_pkg::LEAD2_LO && in_byte <= utf8s_pkg::LEAD2_HI)
        begin
            lead_len  = utf8s_pkg::SEQ_LEN_2;
            lead_bits = {16'd0, in_byte[4:0]};
        end
        else if (in_byte >= utf8s_pkg::LEAD3_LO && in_byte <= utf8s_pkg::LEAD3_HI)
        begin
            lead_len  = utf8s_pkg::SEQ_LEN_3;
            lead_bits = {17'd0, in_byte[3:0]};
        end
        else if (in_byte >= utf8s_pkg::LEAD4_LO && in_byte <= utf8s_pkg::LEAD4_HI)
        begin
            lead_len  = utf8s_pkg::SEQ_LEN_4;
            lead_bits = {18'd0, in_byte[2:0]};
        end
    end

    // Build the command and the next decode state
    always_comb
    begin
        pc_next   = pc_reg;
        el_next   = el_reg;
        acc_next  = acc_reg;
        pend_we   = 1'b0;
        pend_idx  = pc_reg;
        cmd.repl_cnt = 3'd0;
        cmd.raw_cnt  = 3'd0;
        cmd.fin      = final_byte;
        for (int i = 0; i < 3; i++)
        begin
            cmd.raw[i] = (2'(i) < pc_reg) ? pend_reg[i] : in_byte;
        end
        cmd.raw[3] = in_byte;

        if (pc_reg != 2'd0 && is_cont)
        begin
            if (complete)
            begin
                // Sequence done: pass it through or replace every byte
                if (code_ok)
                    cmd.raw_cnt = pc_inc;
                else
                    cmd.repl_cnt = pc_inc;
                pc_next  = 2'd0;
                el_next  = 3'd0;
                acc_next = '0;
            end
            else
            begin
                // Hold the continuation byte
                pend_we  = 1'b1;
                pc_next  = pc_inc[1:0];
                acc_next = acc_shift;
                if (final_byte)
                begin
                    cmd.repl_cnt = pc_inc;
                    pc_next  = 2'd0;
                    el_next  = 3'd0;
                    acc_next = '0;
                end
            end
        end
        else
        begin
            // Drop any held bytes as replacements, then treat byte as a lead
            cmd.repl_cnt = {1'b0, pc_reg};
            pc_next  = 2'd0;
            el_next  = 3'd0;
            acc_next = '0;
            if (!in_byte[7])
            begin
                cmd.raw[0]  = in_byte;
                cmd.raw_cnt = 3'd1;
            end
            else if (lead_len != utf8s_pkg::SEQ_LEN_NONE && !final_byte)
            begin
                pend_we  = 1'b1;
                pend_idx = 2'd0;
                pc_next  = 2'd1;
                el_next  = lead_len;
                acc_next = lead_bits;
            end
            else
            begin
                cmd.repl_cnt = pc_inc;
            end
        end
        cmd_valid = (cmd.repl_cnt != 3'd0) || (cmd.raw_cnt != 3'd0);
    end

    // Advance decode state on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= 2'd0;
            el_reg  <= 3'd0;
            acc_reg <= '0;
        end
        else if (accept)
        begin
            pc_reg  <= pc_next;
            el_reg  <= el_next;
            acc_reg <= acc_next;
        end
    end

    // Held bytes need no reset: only entries below the count are read
    always_ff @(posedge clk)
    begin
        if (accept && pend_we)
            pend_reg[pend_idx] <= in_byte;
    end

endmodule

@@ rtl/utf8s_cmd_fifo.sv @@
// Command queue between the front end and the back end of the sanitizer.
// Depends on utf8s_pkg.
module utf8s_cmd_fifo
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  utf8s_pkg::cmd_t  push_data,
    input  logic             pop,
    output utf8s_pkg::cmd_t  head,
    output logic             full,
    output logic             empty
);

    utf8s_pkg::cmd_t                     mem_reg [utf8s_pkg::QDEPTH];
    logic [utf8s_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [utf8s_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [utf8s_pkg::QCNT_W-1:0]        count_reg;
    logic                                do_push;
    logic                                do_pop;

    assign full    = (count_reg == utf8s_pkg::QCNT_W'(utf8s_pkg::QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Store the command
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

@@ rtl/utf8s_back.sv @@
// Back end of the sanitizer: expands the head command into output bytes.
// Depends on utf8s_pkg.
module utf8s_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  utf8s_pkg::cmd_t  head,
    input  logic             head_empty,
    input  logic             pop,
    output logic             head_pop,
    output logic [7:0]       out_byte,
    output logic             run_last,
    output logic             string_end
);

    logic [2:0] rep_done_reg;
    logic [1:0] phase_reg;
    logic [1:0] raw_idx_reg;
    logic       in_repl;
    logic       last;
    logic       take;
    logic [7:0] repl_byte;

    // Select the current byte of the command
    always_comb
    begin
        in_repl = (rep_done_reg < head.repl_cnt);
        case (phase_reg)
            2'd0:    repl_byte = utf8s_pkg::REPL_B0;
            2'd1:    repl_byte = utf8s_pkg::REPL_B1;
            default: repl_byte = utf8s_pkg::REPL_B2;
        endcase
        if (in_repl)
        begin
            out_byte = repl_byte;
            last     = (phase_reg == 2'd2) && (rep_done_reg + 3'd1 == head.repl_cnt) &&
                       (head.raw_cnt == 3'd0);
        end
        else
        begin
            out_byte = head.raw[raw_idx_reg];
            last     = ({1'b0, raw_idx_reg} + 3'd1 == head.raw_cnt);
        end
        run_last   = last;
        string_end = last && head.fin;
        take       = pop && !head_empty;
        head_pop   = take && last;
    end

    // Advance through the command; restart on its last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rep_done_reg <= 3'd0;
            phase_reg    <= 2'd0;
            raw_idx_reg  <= 2'd0;
        end
        else if (take)
        begin
            if (last)
            begin
                rep_done_reg <= 3'd0;
                phase_reg    <= 2'd0;
                raw_idx_reg  <= 2'd0;
            end
            else if (in_repl)
            begin
                if (phase_reg == 2'd2)
                begin
                    phase_reg    <= 2'd0;
                    rep_done_reg <= rep_done_reg + 3'd1;
                end
                else
                begin
                    phase_reg <= phase_reg + 2'd1;
                end
            end
            else
            begin
                raw_idx_reg <= raw_idx_reg + 2'd1;
            end
        end
    end

endmodule

@@ rtl/utf8_sanitizer.sv @@
// UTF-8 sanitizer top level. Results pass through the registered command queue.
// Throughput: one input byte per cycle while each byte yields at most one output byte
// and the queue is not full; an input yielding k output bytes (up to 12) holds the
// back end until popped; the four-entry queue absorbs bursts before push sees full.
// Reset: asynchronous, clears decode state and queue; no clearing pass is needed.
module utf8_sanitizer
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       final_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       string_end
);

    utf8s_pkg::cmd_t front_cmd;
    utf8s_pkg::cmd_t head_cmd;
    logic            front_valid;
    logic            accept;
    logic            q_full;
    logic            q_empty;
    logic            head_pop;

    assign full   = q_full;
    assign empty  = q_empty;
    assign accept = push && !q_full;

    // Decode and hold sequences
    utf8s_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_byte    (in_byte),
        .final_byte (final_byte),
        .accept     (accept),
        .cmd        (front_cmd),
        .cmd_valid  (front_valid)
    );

    // Queue commands between the two halves
    utf8s_cmd_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && front_valid),
        .push_data (front_cmd),
        .pop       (head_pop),
        .head      (head_cmd),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Expand commands into output bytes
    utf8s_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_cmd),
        .head_empty (q_empty),
        .pop        (pop),
        .head_pop   (head_pop),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .string_end (string_end)
    );

endmodule

@@ rtl/utf8s_checker.sv @@
// Port-level checker for the UTF-8 sanitizer, bound to the top level.
// Depends on utf8_sanitizer_assert.svh.
`include "utf8_sanitizer_assert.svh"

module utf8s_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] out_byte,
    input logic       run_last,
    input logic       string_end
);

    // String end closes a transaction run
    `UTF8S_ASSERT_NOW(a_end_is_last, clk, rst_n, !empty && string_end, run_last)

    // Never emit bytes that cannot appear in well-formed UTF-8
    `UTF8S_ASSERT_NOW(a_legal_byte, clk, rst_n, !empty,
        !(out_byte == 8'hC0 || out_byte == 8'hC1 || out_byte >= 8'hF5))

    // An ASCII byte always ends the output of its input transaction
    `UTF8S_ASSERT_NOW(a_ascii_last, clk, rst_n, !empty && !out_byte[7], run_last)

    // A waiting result holds until popped
    `UTF8S_ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop,
        !empty && $stable(out_byte) && $stable(run_last) && $stable(string_end))

endmodule

bind utf8_sanitizer utf8s_checker u_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .string_end (string_end)
);

@@ dv/utf8_sanitizer_tb_pkg.sv @@
`timescale 1ns / 1ps
// Expected-stream tracker for the UTF-8 sanitizer testbench: predicts the cleaned
// byte stream from accepted input transactions and checks every output transaction.
// Depends on utf8s_pkg for the replacement character, lead-byte ranges and limits.
package utf8_sanitizer_tb_pkg;

    typedef struct packed {
        logic [7:0] value;
        logic       run_last;
        logic       string_end;
    } clean_byte_t;

    class utf8_clean_tracker;
        logic [7:0]  held [3];
        logic [1:0]  held_cnt;
        logic [2:0]  seq_len;
        logic [20:0] code_acc;
        clean_byte_t expected_bytes [$];
        clean_byte_t step_bytes [$];
        int          mismatches;
        int          bytes_in;
        int          bytes_out;
        int          strings;
        int          repl_chars;

        function new();
            go_idle();
            mismatches = 0;
            bytes_in   = 0;
            bytes_out  = 0;
            strings    = 0;
            repl_chars = 0;
        endfunction

        function void go_idle();
            held_cnt = '0;
            seq_len  = utf8s_pkg::SEQ_LEN_NONE;
            code_acc = '0;
        endfunction

        function void emit(logic [7:0] b);
            clean_byte_t e;
            e.value      = b;
            e.run_last   = 1'b0;
            e.string_end = 1'b0;
            step_bytes   = {step_bytes, e};
        endfunction

        function void emit_repl(int times);
            repeat (times)
            begin
                emit(utf8s_pkg::REPL_B0);
                emit(utf8s_pkg::REPL_B1);
                emit(utf8s_pkg::REPL_B2);
            end
            repl_chars += times;
        endfunction

        // Predict the output bytes caused by one accepted input transaction
        function void note_input(logic [7:0] b, logic fin);
            logic [2:0]  lead_len;
            logic [20:0] lead_bits;
            logic [20:0] floor_code;
            logic        ok;
            bit          consumed;
            int          last;

            step_bytes.delete();
            consumed = 0;
            bytes_in++;

            // Continue or break a held sequence
            if (held_cnt != 0)
            begin
                if (b[7:6] == 2'b10)
                begin
                    code_acc = {code_acc[14:0], b[5:0]};
                    if (int'(held_cnt) + 1 >= int'(seq_len))
                    begin
                        case (seq_len)
                            utf8s_pkg::SEQ_LEN_2: floor_code = utf8s_pkg::MIN_CODE_2;
                            utf8s_pkg::SEQ_LEN_3: floor_code = utf8s_pkg::MIN_CODE_3;
                            default:              floor_code = utf8s_pkg::MIN_CODE_4;
                        endcase
                        ok = (code_acc >= floor_code) && (code_acc <= utf8s_pkg::MAX_CODE) &&
                             !((code_acc >= utf8s_pkg::SURR_LO) &&
                               (code_acc <= utf8s_pkg::SURR_HI));
                        if (ok)
                        begin
                            for (int i = 0; i < int'(held_cnt); i++)
                                emit(held[i]);
                            emit(b);
                        end
                        else
                        begin
                            emit_repl(int'(held_cnt) + 1);
                        end
                        go_idle();
                    end
                    else
                    begin
                        held[held_cnt] = b;
                        held_cnt       = held_cnt + 2'd1;
                        if (fin)
                        begin
                            emit_repl(int'(held_cnt));
                            go_idle();
                        end
                    end
                    consumed = 1;
                end
                else
                begin
                    emit_repl(int'(held_cnt));
                    go_idle();
                end
            end

            // Handle the byte at a lead position
            if (!consumed)
            begin
                lead_len  = utf8s_pkg::SEQ_LEN_NONE;
                lead_bits = '0;
                if (b < 8'h80)
                begin
                    emit(b);
                end
                else
                begin
                    if (b >= utf8s_pkg::LEAD2_LO && b <= utf8s_pkg::LEAD2_HI)
                    begin
                        lead_len  = utf8s_pkg::SEQ_LEN_2;
                        lead_bits = 21'(b[4:0]);
                    end
                    else if (b >= utf8s_pkg::LEAD3_LO && b <= utf8s_pkg::LEAD3_HI)
                    begin
                        lead_len  = utf8s_pkg::SEQ_LEN_3;
                        lead_bits = 21'(b[3:0]);
                    end
                    else if (b >= utf8s_pkg::LEAD4_LO && b <= utf8s_pkg::LEAD4_HI)
                    begin
                        lead_len  = utf8s_pkg::SEQ_LEN_4;
                        lead_bits = 21'(b[2:0]);
                    end
                    if (lead_len == utf8s_pkg::SEQ_LEN_NONE || fin)
                    begin
                        emit_repl(1);
                    end
                    else
                    begin
                        held[0]  = b;
                        held_cnt = 2'd1;
                        seq_len  = lead_len;
                        code_acc = lead_bits;
                    end
                end
            end

            // Mark the end of this run and of the string
            if (step_bytes.size() > 0)
            begin
                last = step_bytes.size() - 1;
                step_bytes[last].run_last = 1'b1;
                if (fin)
                    step_bytes[last].string_end = 1'b1;
            end
            if (fin)
                strings++;
            foreach (step_bytes[i])
                expected_bytes = {expected_bytes, step_bytes[i]};
        endfunction

        // Compare one output transaction with the oldest expected byte
        function void check_output(logic [7:0] value, logic run_last, logic string_end);
            clean_byte_t want;

            bytes_out++;
            if (expected_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected output byte %02h run_last %0b string_end %0b",
                             value, run_last, string_end);
                return;
            end
            want = expected_bytes.pop_front();
            if (want.value !== value || want.run_last !== run_last ||
                want.string_end !== string_end)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: output byte %0d: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                             bytes_out, want.value, want.run_last, want.string_end,
                             value, run_last, string_end);
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        function void report_leftovers();
            if (expected_bytes.size() != 0)
            begin
                mismatches++;
                $display("ERROR: %0d expected output bytes never arrived",
                         expected_bytes.size());
            end
        endfunction
    endclass

endpackage

@@ dv/tb_utf8_sanitizer.sv @@
`timescale 1ns / 1ps
// Top-level testbench of utf8_sanitizer: directed and random byte strings, random
// stalls on both sides and one long output hold-off.
// Depends on utf8s_pkg, utf8_sanitizer_tb_pkg and the utf8_sanitizer RTL.
module tb_utf8_sanitizer;

    localparam int NUM_ITEMS       = 450;
    localparam int QUIET_TAIL      = 60;
    localparam int PRESSURE_AT     = 150;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 16;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } text_in_t;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] in_byte;
    logic       final_byte;
    logic       empty;
    logic       pop;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;

    utf8_sanitizer_tb_pkg::utf8_clean_tracker tracker = new();
    text_in_t          stim_q [$];
    logic [7:0]        str_bytes [$];
    int                bytes_accepted = 0;
    int                idle_cycles = 0;
    bit                quiet = 0;
    bit                pressure_done = 0;

    utf8_sanitizer dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .in_byte    (in_byte),
        .final_byte (final_byte),
        .empty      (empty),
        .pop        (pop),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .string_end (string_end)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [7:0] cont_byte();
        return 8'(8'h80 | $urandom_range(0, 63));
    endfunction

    // Add one byte to the end of the current string
    function automatic void append_byte(logic [7:0] b);
        str_bytes = {str_bytes, b};
    endfunction

    // Append the UTF-8 encoding of a code point to the current string
    function automatic void encode_code(int unsigned cp);
        if (cp < 'h80)
        begin
            append_byte(8'(cp));
        end
        else if (cp < 'h800)
        begin
            append_byte(8'(8'hC0 | (cp >> 6)));
            append_byte(8'(8'h80 | (cp & 'h3F)));
        end
        else if (cp < 'h10000)
        begin
            append_byte(8'(utf8s_pkg::LEAD3_LO | (cp >> 12)));
            append_byte(8'(8'h80 | ((cp >> 6) & 'h3F)));
            append_byte(8'(8'h80 | (cp & 'h3F)));
        end
        else
        begin
            append_byte(8'(utf8s_pkg::LEAD4_LO | (cp >> 18)));
            append_byte(8'(8'h80 | ((cp >> 12) & 'h3F)));
            append_byte(8'(8'h80 | ((cp >> 6) & 'h3F)));
            append_byte(8'(8'h80 | (cp & 'h3F)));
        end
    endfunction

    // Move the current string into the stimulus, final flag on its last byte
    function automatic void close_string();
        text_in_t item;
        foreach (str_bytes[i])
        begin
            item.value = str_bytes[i];
            item.last  = (i == str_bytes.size() - 1);
            stim_q     = {stim_q, item};
        end
        str_bytes.delete();
    endfunction

    // Add one piece of text: mostly well-formed characters, some noise
    function automatic void add_piece();
        int unsigned pick;
        int unsigned cp;
        int          start;

        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            append_byte(8'($urandom_range(0, 127)));
        end
        else if (pick < 40)
        begin
            encode_code($urandom_range('h80, 'h7FF));
        end
        else if (pick < 55)
        begin
            cp = $urandom_range('h800, 'hFFFF);
            if (cp >= 'hD800 && cp <= 'hDFFF)
                cp = cp ^ 'h2000;
            encode_code(cp);
        end
        else if (pick < 70)
        begin
            encode_code($urandom_range('h10000, 'h10FFFF));
        end
        else if (pick < 76)
        begin
            append_byte(8'($urandom_range(0, 255)));
        end
        else if (pick < 82)
        begin
            // truncated sequence
            start = str_bytes.size();
            encode_code($urandom_range('h80, 'h10FFFF));
            repeat ($urandom_range(1, str_bytes.size() - start - 1))
                void'(str_bytes.pop_back());
        end
        else if (pick < 88)
        begin
            // overlong forms
            case ($urandom_range(0, 2))
                0:
                begin
                    append_byte(8'(8'hC0 | $urandom_range(0, 1)));
                    append_byte(cont_byte());
                end
                1:
                begin
                    append_byte(utf8s_pkg::LEAD3_LO);
                    append_byte(8'(8'h80 | $urandom_range(0, 31)));
                    append_byte(cont_byte());
                end
                default:
                begin
                    append_byte(utf8s_pkg::LEAD4_LO);
                    append_byte(8'(8'h80 | $urandom_range(0, 15)));
                    append_byte(cont_byte());
                    append_byte(cont_byte());
                end
            endcase
        end
        else if (pick < 92)
        begin
            // surrogate
            append_byte(8'hED);
            append_byte(8'(8'hA0 | $urandom_range(0, 31)));
            append_byte(cont_byte());
        end
        else if (pick < 96)
        begin
            // beyond the last code point
            if ($urandom_range(0, 1) == 0)
            begin
                append_byte(utf8s_pkg::LEAD4_HI);
                append_byte(8'($urandom_range('h90, 'hBF)));
                append_byte(cont_byte());
                append_byte(cont_byte());
            end
            else
            begin
                append_byte(8'($urandom_range(utf8s_pkg::LEAD4_HI + 1, 'hFF)));
            end
        end
        else
        begin
            append_byte(cont_byte());
        end
    endfunction

    // Offer one input transaction and hold it until accepted
    task automatic send_byte(text_in_t item);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            repeat ($urandom_range(1, 3))
                @(negedge clk) push <= 1'b0;
        end
        @(negedge clk);
        push       <= 1'b1;
        in_byte    <= item.value;
        final_byte <= item.last;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // Observe accepted transactions on both sides; watch for a hang
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (push && !full)
            begin
                tracker.note_input(in_byte, final_byte);
                bytes_accepted++;
            end
            if (pop && !empty)
                tracker.check_output(out_byte, run_last, string_end);
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("ERROR: no transaction for %0d cycles", STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Drain outputs with random stalls and one long hold-off
    initial
    begin
        int hold;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!pressure_done && bytes_accepted >= PRESSURE_AT)
            begin
                hold          = HOLD_OFF_CYCLES;
                pressure_done = 1;
            end
            else if (hold == 0 && !quiet && $urandom_range(0, 4) == 0)
            begin
                hold = $urandom_range(1, 3);
            end
            if (hold > 0)
            begin
                pop <= 1'b0;
                hold--;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        push       = 1'b0;
        pop        = 1'b0;
        in_byte    = 8'h00;
        final_byte = 1'b0;

        // Directed strings: field extremes and special cases
        str_bytes = '{8'h7F, 8'h00};             close_string();
        str_bytes = '{8'hDF, 8'hBF};             close_string();
        str_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF}; close_string();
        str_bytes = '{8'hC1, 8'h80};             close_string();
        str_bytes = '{8'hE0, 8'h80, 8'h80};      close_string();
        str_bytes = '{8'hED, 8'hA0, 8'h80};      close_string();
        str_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80}; close_string();
        str_bytes = '{8'hC3, 8'h41};             close_string();
        str_bytes = '{8'hE2, 8'h82};             close_string();
        str_bytes = '{8'hC3};                    close_string();

        // Random strings
        while (stim_q.size() < NUM_ITEMS)
        begin
            repeat ($urandom_range(1, 6))
                add_piece();
            close_string();
        end

        // Hold reset, then release
        repeat (12) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        foreach (stim_q[i])
        begin
            if (i >= stim_q.size() - QUIET_TAIL)
                quiet = 1;
            send_byte(stim_q[i]);
        end
        @(negedge clk) push <= 1'b0;

        // Wait for every expected byte, then let the pipeline settle
        while (tracker.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        tracker.report_leftovers();

        $display("Covered %0d strings: %0d bytes in, %0d bytes out, %0d replacement characters",
                 tracker.strings, tracker.bytes_in, tracker.bytes_out, tracker.repl_chars);
        $display("Long output hold-off applied: %0d, mismatches: %0d",
                 pressure_done, tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
